/* hw/rtl/tclp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types, character codes and name tables of the command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tclp_pkg;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','

  // Section codes of a result beat
  localparam logic [1:0] SEC_SUM = 2'd0;
  localparam logic [1:0] SEC_PRE = 2'd1;
  localparam logic [1:0] SEC_PAR = 2'd2;
  localparam logic [1:0] SEC_VAL = 2'd3;

  // Command ids
  localparam logic [1:0] CMD_PRINT = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_EN    = 2'd2;
  localparam logic [1:0] CMD_DE    = 2'd3;
  localparam logic [2:0] CMD_NONE  = 3'd4;

  // Line summary handed from the parser to the emitter. Count fields are
  // sized for the largest store sizes the design supports.
  typedef struct packed {
    logic       status;
    logic [2:0] cid;
    logic [2:0] name_len;
    logic [4:0] pre_cnt;
    logic [4:0] par_cnt;
    logic [5:0] val_cnt;
  } line_sum_t;

  function automatic logic [7:0] name_char(input logic [1:0] id, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (id)
      CMD_PRINT: begin
        case (pos)
          3'd0:    c = "p";
          3'd1:    c = "r";
          3'd2:    c = "i";
          3'd3:    c = "n";
          3'd4:    c = "t";
          default: c = 8'h00;
        endcase
      end
      CMD_SET: begin
        case (pos)
          3'd0:    c = "s";
          3'd1:    c = "e";
          3'd2:    c = "t";
          default: c = 8'h00;
        endcase
      end
      CMD_EN: begin
        case (pos)
          3'd0:    c = "e";
          3'd1:    c = "n";
          default: c = 8'h00;
        endcase
      end
      CMD_DE: begin
        case (pos)
          3'd0:    c = "d";
          3'd1:    c = "e";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] name_size(input logic [1:0] id);
    logic [2:0] n;
    case (id)
      CMD_PRINT: n = 3'd5;
      CMD_SET:   n = 3'd3;
      CMD_EN:    n = 3'd2;
      CMD_DE:    n = 3'd2;
      default:   n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tclp_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_mem
// Byte store for prefix, parameter and value text. One write port, one read
// port, registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_mem #(
  parameter int DEPTH = 56,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tclp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_parse
// Line parser: phase machine, name matcher and store counters. Writes text
// bytes into the store and presents the running line summary.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_parse import tclp_pkg::*; #(
  parameter int PREFIX_BYTES = 8,
  parameter int PARAM_BYTES  = 16,
  parameter int VALUE_BYTES  = 32,
  parameter int AW           = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          beat,
  input  wire logic [7:0]    data,
  output logic               we,
  output logic      [AW-1:0] waddr,
  output logic      [7:0]    wdata,
  output line_sum_t          summary
);

  localparam int PCW = $clog2(PREFIX_BYTES + 1);
  localparam int QCW = $clog2(PARAM_BYTES + 1);
  localparam int VCW = $clog2(VALUE_BYTES + 1);

  typedef enum logic [5:0] {
    PH_BEGIN  = 6'b000001,
    PH_PREFIX = 6'b000010,
    PH_NAME   = 6'b000100,
    PH_COMMA  = 6'b001000,
    PH_PARAM  = 6'b010000,
    PH_VALUE  = 6'b100000
  } phase_t;

  phase_t         phase, phase_next;
  logic [PCW-1:0] pc, pc_next;
  logic [QCW-1:0] qc, qc_next;
  logic [VCW-1:0] vc, vc_next;
  logic [1:0]     nm, nm_next;
  logic [2:0]     nc, nc_next;
  logic           clear;
  logic           first_hit;
  logic [1:0]     first_id;
  logic           matched;

  // first letter of a known name; lowest id wins
  always_comb begin
    first_hit = 1'b0;
    first_id  = CMD_PRINT;
    for (int i = 3; i >= 0; i--) begin
      if (name_char(2'(i), 3'd0) == data) begin
        first_hit = 1'b1;
        first_id  = 2'(i);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    pc_next    = pc;
    qc_next    = qc;
    vc_next    = vc;
    nm_next    = nm;
    nc_next    = nc;
    clear      = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = data;
    if (beat) begin
      if (data == CH_NL) begin
        clear = 1'b1;
      end else begin
        case (phase)
          PH_BEGIN: begin
            if (data == CH_PCT) begin
              phase_next = PH_PREFIX;
            end else if (first_hit) begin
              nm_next    = first_id;
              nc_next    = 3'd1;
              phase_next = PH_NAME;
            end
          end
          PH_PREFIX: begin
            if (data == CH_PCT) begin
              phase_next = PH_BEGIN;
            end else if (pc == PCW'(PREFIX_BYTES)) begin
              clear = 1'b1;
            end else begin
              we      = 1'b1;
              waddr   = AW'(pc);
              pc_next = pc + PCW'(1);
            end
          end
          PH_NAME: begin
            if (nc < name_size(nm) && name_char(nm, nc) == data) begin
              nc_next = nc + 3'd1;
              if (nc + 3'd1 == name_size(nm)) begin
                phase_next = PH_COMMA;
              end
            end else begin
              clear = 1'b1;
            end
          end
          PH_COMMA: begin
            if (data == CH_COMMA) begin
              phase_next = PH_PARAM;
            end else begin
              clear = 1'b1;
            end
          end
          PH_PARAM: begin
            if (qc == QCW'(PARAM_BYTES)) begin
              clear = 1'b1;
            end else if (data == CH_COMMA) begin
              phase_next = PH_VALUE;
            end else begin
              we      = 1'b1;
              waddr   = AW'(PREFIX_BYTES) + AW'(qc);
              qc_next = qc + QCW'(1);
            end
          end
          PH_VALUE: begin
            if (vc == VCW'(VALUE_BYTES)) begin
              clear = 1'b1;
            end else begin
              we      = 1'b1;
              waddr   = AW'(PREFIX_BYTES + PARAM_BYTES) + AW'(vc);
              vc_next = vc + VCW'(1);
            end
          end
          default: clear = 1'b1;
        endcase
      end
    end
    if (clear) begin
      phase_next = PH_BEGIN;
      pc_next    = '0;
      qc_next    = '0;
      vc_next    = '0;
      nm_next    = CMD_PRINT;
      nc_next    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BEGIN;
      pc    <= '0;
      qc    <= '0;
      vc    <= '0;
      nm    <= CMD_PRINT;
      nc    <= 3'd0;
    end else begin
      phase <= phase_next;
      pc    <= pc_next;
      qc    <= qc_next;
      vc    <= vc_next;
      nm    <= nm_next;
      nc    <= nc_next;
    end
  end

  // a name counts only once its comma phase is reached
  assign matched = (phase == PH_COMMA) || (phase == PH_PARAM) || (phase == PH_VALUE);

  always_comb begin
    summary.status   = (phase == PH_BEGIN) ? (pc == '0) : !matched;
    summary.cid      = matched ? {1'b0, nm} : CMD_NONE;
    summary.name_len = nc;
    summary.pre_cnt  = 5'(pc);
    summary.par_cnt  = 5'(qc);
    summary.val_cnt  = 6'(vc);
  end

endmodule

`default_nettype wire

/* hw/rtl/tclp_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_emit
// Result sequencer: walks summary, prefix, parameter and value items of a
// finished line, reads the store one item ahead and fills the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_emit import tclp_pkg::*; #(
  parameter int PREFIX_BYTES = 8,
  parameter int PARAM_BYTES  = 16,
  parameter int VALUE_BYTES  = 32,
  parameter int AW           = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire line_sum_t     summary,
  output logic               active,
  output logic               re,
  output logic      [AW-1:0] raddr,
  input  wire logic [7:0]    rdata,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic      [1:0]    section,
  output logic               status,
  output logic      [2:0]    command_id,
  output logic      [2:0]    name_length,
  output logic      [3:0]    prefix_length,
  output logic      [4:0]    param_length,
  output logic      [5:0]    value_length,
  output logic      [4:0]    char_index,
  output logic      [7:0]    char_value,
  output logic               last
);

  localparam int MAXB = (PREFIX_BYTES > PARAM_BYTES)
                        ? ((PREFIX_BYTES > VALUE_BYTES) ? PREFIX_BYTES : VALUE_BYTES)
                        : ((PARAM_BYTES > VALUE_BYTES) ? PARAM_BYTES : VALUE_BYTES);
  localparam int IW   = (MAXB > 1) ? $clog2(MAXB) : 1;

  line_sum_t     sumr;
  logic          walking;
  logic [1:0]    cur_sec;
  logic [IW-1:0] cur_idx;
  logic          pend;
  logic [1:0]    pend_sec;
  logic [IW-1:0] pend_idx;
  logic          pend_last;

  logic          load;
  logic          issue;
  logic [5:0]    cur_cnt;
  logic          more_here;
  logic          has_next;
  logic [1:0]    nxt_sec;
  logic [IW-1:0] nxt_idx;

  assign load  = pend && (!out_valid || out_ready);
  assign issue = walking && (!pend || load);

  always_comb begin
    case (cur_sec)
      SEC_PRE: cur_cnt = 6'(sumr.pre_cnt);
      SEC_PAR: cur_cnt = 6'(sumr.par_cnt);
      SEC_VAL: cur_cnt = sumr.val_cnt;
      default: cur_cnt = 6'd0;
    endcase
  end

  assign more_here = (cur_sec != SEC_SUM) && ((6'(cur_idx) + 6'd1) < cur_cnt);

  // next item: rest of this section, else first non-empty later section
  always_comb begin
    has_next = 1'b1;
    nxt_sec  = cur_sec;
    nxt_idx  = cur_idx + IW'(1);
    if (!more_here) begin
      nxt_idx = '0;
      if (cur_sec == SEC_SUM && sumr.pre_cnt != '0) begin
        nxt_sec = SEC_PRE;
      end else if ((cur_sec == SEC_SUM || cur_sec == SEC_PRE) && sumr.par_cnt != '0) begin
        nxt_sec = SEC_PAR;
      end else if (cur_sec != SEC_VAL && sumr.val_cnt != '0) begin
        nxt_sec = SEC_VAL;
      end else begin
        has_next = 1'b0;
      end
    end
  end

  always_comb begin
    case (cur_sec)
      SEC_PRE: raddr = AW'(cur_idx);
      SEC_PAR: raddr = AW'(PREFIX_BYTES) + AW'(cur_idx);
      SEC_VAL: raddr = AW'(PREFIX_BYTES + PARAM_BYTES) + AW'(cur_idx);
      default: raddr = '0;
    endcase
  end

  assign re     = issue && (cur_sec != SEC_SUM);
  assign active = walking || pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      pend    <= 1'b0;
    end else begin
      if (start) begin
        walking <= 1'b1;
      end else if (issue && !has_next) begin
        walking <= 1'b0;
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sumr    <= summary;
      cur_sec <= SEC_SUM;
      cur_idx <= '0;
    end else if (issue && has_next) begin
      cur_sec <= nxt_sec;
      cur_idx <= nxt_idx;
    end
    if (issue) begin
      pend_sec  <= cur_sec;
      pend_idx  <= cur_idx;
      pend_last <= !has_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      section       <= pend_sec;
      status        <= sumr.status;
      command_id    <= sumr.cid;
      name_length   <= sumr.name_len;
      prefix_length <= 4'(sumr.pre_cnt);
      param_length  <= sumr.par_cnt;
      value_length  <= sumr.val_cnt;
      char_index    <= 5'(pend_idx);
      char_value    <= (pend_sec == SEC_SUM) ? 8'h00 : rdata;
      last          <= pend_last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_command_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_line_parser
// Parses [%prefix%]name[,param[,value]] lines a byte at a time and emits a
// summary beat plus every stored text byte when a newline arrives.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+---------------------
//  in      | in_valid / in_ready            | sink      | data_byte
//  out     | out_valid / out_ready          | source    | section .. last
//
//  Text bytes go in one per cycle through the store's write port.
//  A newline starts the output: 1 + stored-byte beats leave at one
//  per cycle while out_ready is high, paced by the store's read port; input
//  stalls until the last beat of the line sits in the output register.
//  rst is synchronous; no store clearing pass is needed after reset.
//  out_ready low holds the output register and the read pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module text_command_line_parser import tclp_pkg::*; #(
  parameter int PREFIX_BYTES = 8,
  parameter int PARAM_BYTES  = 16,
  parameter int VALUE_BYTES  = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [1:0] section,
  output logic            status,
  output logic      [2:0] command_id,
  output logic      [2:0] name_length,
  output logic      [3:0] prefix_length,
  output logic      [4:0] param_length,
  output logic      [5:0] value_length,
  output logic      [4:0] char_index,
  output logic      [7:0] char_value,
  output logic            last
);

  localparam int DEPTH = PREFIX_BYTES + PARAM_BYTES + VALUE_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic          in_beat;
  logic          line_end;
  logic          active;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  line_sum_t     summary;

  assign in_ready = !active;
  assign in_beat  = in_valid && in_ready;
  assign line_end = in_beat && (data_byte == CH_NL);

  tclp_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  tclp_parse #(
    .PREFIX_BYTES (PREFIX_BYTES),
    .PARAM_BYTES  (PARAM_BYTES),
    .VALUE_BYTES  (VALUE_BYTES),
    .AW           (AW)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .beat    (in_beat),
    .data    (data_byte),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .summary (summary)
  );

  tclp_emit #(
    .PREFIX_BYTES (PREFIX_BYTES),
    .PARAM_BYTES  (PARAM_BYTES),
    .VALUE_BYTES  (VALUE_BYTES),
    .AW           (AW)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .start         (line_end),
    .summary       (summary),
    .active        (active),
    .re            (re),
    .raddr         (raddr),
    .rdata         (rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .section       (section),
    .status        (status),
    .command_id    (command_id),
    .name_length   (name_length),
    .prefix_length (prefix_length),
    .param_length  (param_length),
    .value_length  (value_length),
    .char_index    (char_index),
    .char_value    (char_value),
    .last          (last)
  );

`ifndef ASSERT_OFF
  // a newline beat blocks input until its last item is in the output register
  a_nl_stalls: assert property (@(posedge clk) disable iff (rst)
    line_end |=> !in_ready)
    else $error("input not stalled after newline beat");

  // items of one line leave back to back
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside a line's result beats");

  // a line's first beat is its summary
  a_sum_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || section == SEC_SUM)
    else $error("line did not start with a summary beat");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command line parser: directed command lines
// with random filler bytes go in byte by byte, a local parser predicts every
// result beat, and a monitor checks each accepted beat field by field.
// ----------------------------------------------------------------------------

module tb;
  import tclp_pkg::*;

  localparam int PRE_CAP     = 8;
  localparam int PAR_CAP     = 16;
  localparam int VAL_CAP     = 32;
  localparam int IDLE_PCT    = 14;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 80;

  typedef enum logic [2:0] {
    PH_BEGIN  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_NAME   = 3'd2,
    PH_COMMA  = 3'd3,
    PH_PARAM  = 3'd4,
    PH_VALUE  = 3'd5
  } line_phase_t;

  typedef struct {
    logic [1:0] section;
    logic       status;
    logic [2:0] cid;
    logic [2:0] name_len;
    logic [3:0] pre_len;
    logic [4:0] par_len;
    logic [5:0] val_len;
    logic [4:0] idx;
    logic [7:0] chr;
    logic       last;
  } line_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] section;
  logic       status;
  logic [2:0] command_id;
  logic [2:0] name_length;
  logic [3:0] prefix_length;
  logic [4:0] param_length;
  logic [5:0] value_length;
  logic [4:0] char_index;
  logic [7:0] char_value;
  logic       last;

  text_command_line_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .section      (section),
    .status       (status),
    .command_id   (command_id),
    .name_length  (name_length),
    .prefix_length(prefix_length),
    .param_length (param_length),
    .value_length (value_length),
    .char_index   (char_index),
    .char_value   (char_value),
    .last         (last)
  );

  // stimulus and expectations
  logic [7:0] pending_bytes[$];
  line_beat_t expected_beats[$];
  int         in_beats = 0;
  int         fail_count = 0;
  int         cycles = 0;
  int         hold_at = 0;
  int         calm_lo = 0;
  int         calm_hi = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       calm;

  assign calm = (in_beats >= calm_lo) && (in_beats < calm_hi);

  // local copy of the parser state
  string       cmd_names[4] = '{"print", "set", "en", "de"};
  line_phase_t ph;
  logic [7:0]  prefix_mem[PRE_CAP];
  logic [7:0]  param_mem[PAR_CAP];
  logic [7:0]  value_mem[VAL_CAP];
  int          prefix_n, param_n, value_n, name_n;
  logic [1:0]  cmd_sel;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic reset_parser();
    ph       = PH_BEGIN;
    prefix_n = 0;
    param_n  = 0;
    value_n  = 0;
    name_n   = 0;
    cmd_sel  = CMD_PRINT;
  endtask

  task automatic push_beat(input logic [1:0] sec, input logic st, input logic [2:0] cid,
                           input int idx, input logic [7:0] chr, input logic lst);
    line_beat_t bt;
    bt.section  = sec;
    bt.status   = st;
    bt.cid      = cid;
    bt.name_len = name_n[2:0];
    bt.pre_len  = prefix_n[3:0];
    bt.par_len  = param_n[4:0];
    bt.val_len  = value_n[5:0];
    bt.idx      = idx[4:0];
    bt.chr      = chr;
    bt.last     = lst;
    expected_beats.push_back(bt);
  endtask

  // Advance the local parser by one byte; a newline queues the line's beats.
  task automatic parse_byte(input logic [7:0] b);
    logic       st;
    logic [2:0] cid;
    int         total, k, i;
    if (b == CH_NL) begin
      if (ph == PH_BEGIN) st = (prefix_n == 0);
      else st = (ph < PH_COMMA);
      cid   = (ph >= PH_COMMA) ? {1'b0, cmd_sel} : CMD_NONE;
      total = 1 + prefix_n + param_n + value_n;
      k     = 1;
      push_beat(SEC_SUM, st, cid, 0, 8'h00, total == 1);
      for (i = 0; i < prefix_n; i++) begin
        k++;
        push_beat(SEC_PRE, st, cid, i, prefix_mem[i], k == total);
      end
      for (i = 0; i < param_n; i++) begin
        k++;
        push_beat(SEC_PAR, st, cid, i, param_mem[i], k == total);
      end
      for (i = 0; i < value_n; i++) begin
        k++;
        push_beat(SEC_VAL, st, cid, i, value_mem[i], k == total);
      end
      reset_parser();
    end else begin
      case (ph)
        PH_BEGIN: begin
          if (b == CH_PCT) begin
            ph = PH_PREFIX;
          end else begin
            for (i = 0; i < 4; i++) begin
              if (ph == PH_BEGIN && cmd_names[i][0] == b) begin
                cmd_sel = i[1:0];
                name_n  = 1;
                ph      = PH_NAME;
              end
            end
          end
        end
        PH_PREFIX: begin
          if (b == CH_PCT) ph = PH_BEGIN;
          else if (prefix_n >= PRE_CAP) reset_parser();
          else begin
            prefix_mem[prefix_n] = b;
            prefix_n++;
          end
        end
        PH_NAME: begin
          if (name_n < cmd_names[cmd_sel].len() && cmd_names[cmd_sel][name_n] == b) begin
            name_n++;
            if (name_n == cmd_names[cmd_sel].len()) ph = PH_COMMA;
          end else begin
            reset_parser();
          end
        end
        PH_COMMA: begin
          if (b == CH_COMMA) ph = PH_PARAM;
          else reset_parser();
        end
        PH_PARAM: begin
          if (param_n >= PAR_CAP) reset_parser();
          else if (b == CH_COMMA) ph = PH_VALUE;
          else begin
            param_mem[param_n] = b;
            param_n++;
          end
        end
        PH_VALUE: begin
          if (value_n >= VAL_CAP) reset_parser();
          else begin
            value_mem[value_n] = b;
            value_n++;
          end
        end
        default: reset_parser();
      endcase
    end
  endtask

  // ---- stimulus builders ----
  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  // random bytes, never a newline and never the given separator
  task automatic add_rand(input int n, input logic [7:0] avoid);
    logic [7:0] b;
    int         i;
    for (i = 0; i < n; i++) begin
      b = $urandom_range(0, 255);
      while (b == CH_NL || b == avoid) b = $urandom_range(0, 255);
      pending_bytes.push_back(b);
    end
  endtask

  initial begin
    add_text("print\n");
    add_text("%ab%set,p,v\n");
    add_text("en,\n");
    add_text("de,x,\n");
    add_text("\n");
    add_text("xyz?de\n");          // idle bytes before a name
    add_text("pri\n");             // line ends inside the name
    add_text("pz,a\n");            // unknown name
    add_text("setx,a\n");          // missing comma
    add_text("%pre\n");            // line ends inside the prefix
    add_text("%pre%\n");           // prefix only
    add_text("%12%%34%en,q\n");    // prefix gathered in two parts
    add_text("%123456789print,a\n");  // prefix overflow
    add_text("set,");
    add_rand(PAR_CAP, CH_COMMA);
    add_text(",v\n");              // comma on a full parameter store
    add_text("%");
    add_rand(PRE_CAP, CH_PCT);     // full prefix, closing '%' still taken
    add_text("%print,");
    add_rand(PAR_CAP, CH_COMMA);
    add_text(",");
    add_rand(VAL_CAP, CH_NL);      // every store full: longest line
    add_text("\n");
    hold_at = 40;
    calm_lo = 100;
    calm_hi = 150;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // driver: one byte beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      reset_parser();
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(data_byte);
        in_beats <= in_beats + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid  <= 1'b1;
          data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_beats >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string fname, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    line_beat_t bt;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual section %0d value %0d",
                 $time, section, char_value);
        fail_count++;
      end else begin
        bt = expected_beats.pop_front();
        check_field("section", bt.section, section);
        check_field("status", bt.status, status);
        check_field("command_id", bt.cid, command_id);
        check_field("name_length", bt.name_len, name_length);
        check_field("prefix_length", bt.pre_len, prefix_length);
        check_field("param_length", bt.par_len, param_length);
        check_field("value_length", bt.val_len, value_length);
        check_field("char_index", bt.idx, char_index);
        check_field("char_value", bt.chr, char_value);
        check_field("last", bt.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
